FILE: rtl/core/hsc_pkg.sv
// Shared types, status codes and bit-layout helpers for the SECDED byte-pair codec.
// No dependencies; the codec top level and hsc_dec_block use this package.
package hsc_pkg;

  // Per-block correction status codes.
  localparam logic [1:0] StNone   = 2'd0;
  localparam logic [1:0] StSingle = 2'd1;
  localparam logic [1:0] StDouble = 2'd2;

  // Mode values.
  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  data_byte;
    logic [15:0] code_word_in;
  } in_req_t;

  typedef struct packed {
    logic [15:0] code_word_out;
    logic [7:0]  data_raw;
    logic [7:0]  data_corrected;
    logic [2:0]  syndrome_high;
    logic [2:0]  syndrome_low;
    logic        parity_odd_high;
    logic        parity_odd_low;
    logic [1:0]  status_high;
    logic [1:0]  status_low;
  } out_req_t;

  // Check result of one 8-bit block.
  typedef struct packed {
    logic [2:0] syndrome;
    logic       parity_odd;
    logic [1:0] status;
    logic [7:0] corrected;
  } blk_chk_t;

  // Data nibble held at bits 6,5,4,2 of a block.
  function automatic logic [3:0] blk_data(input logic [7:0] blk);
    blk_data = {blk[6], blk[5], blk[4], blk[2]};
  endfunction

endpackage

FILE: rtl/core/hamming_secded_byte_pair_codec_unit.sv
// Top level of the extended Hamming (8,4) SECDED byte-pair codec.
// Depends on hsc_pkg, hsc_enc_block and hsc_dec_block.
//
// Two-stage codec: a request register feeds XOR-only encode/decode logic whose
// result is captured in a result register. A request can enter every cycle
// while in_stall_o is low; it passes the request register, then the result
// register. Encode mode (mode 0) codes the high nibble of data_byte into
// the upper byte of code_word_out and the low nibble into the lower byte; all
// other result fields are zero. Decode mode (mode 1) checks each byte of
// code_word_in on its own: syndrome, overall parity, status (none, single
// corrected, double detected), the corrected word, and the data bits before and
// after correction. A double error leaves its block unchanged. While the
// result register is stalled, the request register still takes one more
// request, so the input side is stalled only when both stages are full and the
// output is stalled. The block holds no other state.
module hamming_secded_byte_pair_codec_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hsc_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hsc_pkg::out_req_t out_req_o
);

  // Stage 1: request register
  logic              s1_valid_q;
  hsc_pkg::in_req_t  s1_req_q;
  // Stage 2: result register
  logic              s2_valid_q;
  hsc_pkg::out_req_t s2_req_q, s2_req_d;

  logic s2_load;
  logic s1_load;

  // Result register moves when empty or drained this cycle.
  assign s2_load    = s1_valid_q && (!s2_valid_q || !out_stall_i);
  // Request register frees up when its content moves on.
  assign in_stall_o = s1_valid_q && !s2_load;
  assign s1_load    = in_valid_i && !in_stall_o;

  // Encoders
  logic [7:0] enc_hi, enc_lo;

  hsc_enc_block u_enc_hi (
    .nibble_i (s1_req_q.data_byte[7:4]),
    .block_o  (enc_hi)
  );

  hsc_enc_block u_enc_lo (
    .nibble_i (s1_req_q.data_byte[3:0]),
    .block_o  (enc_lo)
  );

  // Decoders
  hsc_pkg::blk_chk_t chk_hi, chk_lo;

  hsc_dec_block u_dec_hi (
    .block_i (s1_req_q.code_word_in[15:8]),
    .chk_o   (chk_hi)
  );

  hsc_dec_block u_dec_lo (
    .block_i (s1_req_q.code_word_in[7:0]),
    .chk_o   (chk_lo)
  );

  always_comb begin
    s2_req_d = '0;
    if (s1_req_q.mode == hsc_pkg::ModeEncode) begin
      s2_req_d.code_word_out = {enc_hi, enc_lo};
    end else begin
      s2_req_d.code_word_out   = {chk_hi.corrected, chk_lo.corrected};
      s2_req_d.data_raw        = {hsc_pkg::blk_data(s1_req_q.code_word_in[15:8]),
                                  hsc_pkg::blk_data(s1_req_q.code_word_in[7:0])};
      s2_req_d.data_corrected  = {hsc_pkg::blk_data(chk_hi.corrected),
                                  hsc_pkg::blk_data(chk_lo.corrected)};
      s2_req_d.syndrome_high   = chk_hi.syndrome;
      s2_req_d.syndrome_low    = chk_lo.syndrome;
      s2_req_d.parity_odd_high = chk_hi.parity_odd;
      s2_req_d.parity_odd_low  = chk_lo.parity_odd;
      s2_req_d.status_high     = chk_hi.status;
      s2_req_d.status_low      = chk_lo.status;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s2_load) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_req_q <= in_req_i;
    end
    if (s2_load) begin
      s2_req_q <= s2_req_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_req_o   = s2_req_q;

`ifndef SYNTHESIS
  // Input side only stalls with a pending request in stage 1.
  a_stall_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty request register");

  // A request held back by the result register is not dropped.
  a_pending_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_load) |=> s1_valid_q)
    else $error("pending request lost");

  // Single correction only with odd overall parity.
  a_single_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.status_high == hsc_pkg::StSingle) |->
      out_req_o.parity_odd_high)
    else $error("single correction with even parity");

  // Double detection means nonzero syndrome, even parity, word left unchanged.
  a_double_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.status_low == hsc_pkg::StDouble) |->
      (out_req_o.syndrome_low != 3'd0 && !out_req_o.parity_odd_low &&
       out_req_o.data_raw[3:0] == out_req_o.data_corrected[3:0]))
    else $error("double detection inconsistent");
`endif

endmodule

FILE: rtl/core/hsc_enc_block.sv
// Extended Hamming (8,4) encoder for one nibble.
// No dependencies; it follows the same bit layout as hsc_pkg::blk_data.
module hsc_enc_block (
  input  logic [3:0] nibble_i,
  output logic [7:0] block_o
);

  logic [6:0] low7;

  // Layout {p, d3, d2, d1, c2, d0, c1, c0}
  always_comb begin
    low7[6] = nibble_i[3];
    low7[5] = nibble_i[2];
    low7[4] = nibble_i[1];
    low7[3] = nibble_i[3] ^ nibble_i[2] ^ nibble_i[1];
    low7[2] = nibble_i[0];
    low7[1] = nibble_i[3] ^ nibble_i[2] ^ nibble_i[0];
    low7[0] = nibble_i[3] ^ nibble_i[1] ^ nibble_i[0];
  end

  assign block_o = {^low7, low7};

endmodule

FILE: rtl/core/hsc_dec_block.sv
// SECDED check and correction of one extended Hamming (8,4) block.
// Depends on hsc_pkg for the status codes and the blk_chk_t result struct.
module hsc_dec_block (
  input  logic [7:0]       block_i,
  output hsc_pkg::blk_chk_t chk_o
);

  logic [2:0] syn;
  logic       odd;
  logic [7:0] flip;

  // Syndrome bit j is the parity of the bits whose position (index plus one) has bit j set.
  assign syn[0] = block_i[0] ^ block_i[2] ^ block_i[4] ^ block_i[6];
  assign syn[1] = block_i[1] ^ block_i[2] ^ block_i[5] ^ block_i[6];
  assign syn[2] = block_i[3] ^ block_i[4] ^ block_i[5] ^ block_i[6];
  assign odd    = ^block_i;

  always_comb begin
    flip          = 8'h00;
    chk_o.status  = hsc_pkg::StNone;
    if (syn == 3'd0) begin
      if (odd) begin
        // overall parity bit itself is bad
        flip         = 8'h80;
        chk_o.status = hsc_pkg::StSingle;
      end
    end else if (odd) begin
      flip         = 8'h01 << (syn - 3'd1);
      chk_o.status = hsc_pkg::StSingle;
    end else begin
      chk_o.status = hsc_pkg::StDouble;
    end
    chk_o.syndrome   = syn;
    chk_o.parity_odd = odd;
    chk_o.corrected  = block_i ^ flip;
  end

endmodule

FILE: sim/tb_hamming_secded_byte_pair_codec_unit.sv
// Testbench for the SECDED byte-pair codec: random and directed requests checked
// against a local predictor of the encode and decode/correct functions.
// Depends on hsc_pkg and the codec top level only.
module tb_hamming_secded_byte_pair_codec_unit;

  localparam int QuietLimit   = 1000;  // cycles with no handshake before giving up
  localparam int ItemsPerPass = 600;   // random requests per idling pattern
  localparam int SettleCycles = 10;    // leave margin after the final drain

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  hsc_pkg::in_req_t  in_req_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  hsc_pkg::out_req_t out_req_o;

  // Requests waiting to be driven, and codec results still owed by the block.
  hsc_pkg::in_req_t  pending_requests[$];
  hsc_pkg::out_req_t expected_results[$];
  // Mode of each owed result, in the same order.
  logic              expected_modes[$];

  // Idling odds in percent, changed only between passes.
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  int fail_count     = 0;
  int quiet_cycles   = 0;
  int encode_seen    = 0;
  int decode_seen    = 0;
  int blocks_clean   = 0;
  int blocks_fixed   = 0;
  int blocks_flagged = 0;

  hamming_secded_byte_pair_codec_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  // ---------------------------------------------------------------------------
  // Codec predictor
  // ---------------------------------------------------------------------------

  // Extended Hamming (8,4): data at bits 6,5,4,2, checks at 0,1,3, parity at 7.
  function automatic logic [7:0] encode_nibble(input logic [3:0] nib);
    logic [7:0] blk;
    blk    = '0;
    blk[6] = nib[3];
    blk[5] = nib[2];
    blk[4] = nib[1];
    blk[2] = nib[0];
    blk[0] = nib[3] ^ nib[1] ^ nib[0];
    blk[1] = nib[3] ^ nib[2] ^ nib[0];
    blk[3] = nib[3] ^ nib[2] ^ nib[1];
    blk[7] = ^blk[6:0];
    return blk;
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] blk);
    return {blk[6], blk[5], blk[4], blk[2]};
  endfunction

  // Syndrome, overall parity and SECDED repair of one block.
  function automatic logic [7:0] repair_block(input  logic [7:0] blk,
                                              output logic [2:0] syn,
                                              output logic       odd,
                                              output logic [1:0] st);
    logic [7:0] fixed;
    integer     k;
    syn   = '0;
    fixed = blk;
    for (k = 0; k < 7; k++) begin
      if (blk[k]) syn ^= 3'(k + 1);
    end
    odd = ^blk;
    if (syn == 3'd0 && !odd) begin
      st = hsc_pkg::StNone;
    end else if (syn == 3'd0) begin
      // only the parity bit itself is wrong
      st       = hsc_pkg::StSingle;
      fixed[7] = ~blk[7];
    end else if (odd) begin
      st                  = hsc_pkg::StSingle;
      fixed[syn - 3'd1]   = ~blk[syn - 3'd1];
    end else begin
      // two flips: leave the block alone
      st = hsc_pkg::StDouble;
    end
    return fixed;
  endfunction

  function automatic hsc_pkg::out_req_t predict_codec(input hsc_pkg::in_req_t rq);
    hsc_pkg::out_req_t res;
    logic [7:0]        hi_blk, lo_blk, hi_fix, lo_fix;
    res = '0;
    if (rq.mode == hsc_pkg::ModeEncode) begin
      res.code_word_out = {encode_nibble(rq.data_byte[7:4]),
                           encode_nibble(rq.data_byte[3:0])};
    end else begin
      hi_blk = rq.code_word_in[15:8];
      lo_blk = rq.code_word_in[7:0];
      hi_fix = repair_block(hi_blk, res.syndrome_high, res.parity_odd_high, res.status_high);
      lo_fix = repair_block(lo_blk, res.syndrome_low, res.parity_odd_low, res.status_low);
      res.code_word_out  = {hi_fix, lo_fix};
      res.data_raw       = {nibble_of(hi_blk), nibble_of(lo_blk)};
      res.data_corrected = {nibble_of(hi_fix), nibble_of(lo_fix)};
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------

  function automatic hsc_pkg::in_req_t make_request(input logic mode, input logic [7:0] db,
                                                    input logic [15:0] cw);
    hsc_pkg::in_req_t rq;
    rq.mode         = mode;
    rq.data_byte    = db;
    rq.code_word_in = cw;
    return rq;
  endfunction

  // Flip none, one or two distinct bits of a block.
  function automatic logic [7:0] inject_errors(input logic [7:0] blk);
    logic [7:0] hit;
    int         first_bit, second_bit, roll;
    hit        = blk;
    first_bit  = $urandom_range(0, 7);
    second_bit = (first_bit + 1 + $urandom_range(0, 6)) % 8;
    roll       = $urandom_range(0, 7);
    if (roll >= 3) hit[first_bit] = ~hit[first_bit];
    if (roll >= 6) hit[second_bit] = ~hit[second_bit];
    return hit;
  endfunction

  // Mostly decodes of real codewords with a few injected errors, plus encodes
  // and raw noise words. Unused fields always carry random junk.
  function automatic hsc_pkg::in_req_t random_request();
    hsc_pkg::in_req_t rq;
    int               pick;
    rq.mode         = hsc_pkg::ModeDecode;
    rq.data_byte    = 8'($urandom);
    rq.code_word_in = 16'($urandom);
    pick            = $urandom_range(0, 9);
    if (pick < 3) begin
      rq.mode = hsc_pkg::ModeEncode;
    end else if (pick < 8) begin
      rq.code_word_in = {inject_errors(encode_nibble(4'($urandom))),
                         inject_errors(encode_nibble(4'($urandom)))};
    end
    return rq;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_result(input hsc_pkg::out_req_t exp_r, input hsc_pkg::out_req_t act_r);
    check_field("code_word_out", 16'(exp_r.code_word_out), 16'(act_r.code_word_out));
    check_field("data_raw", 16'(exp_r.data_raw), 16'(act_r.data_raw));
    check_field("data_corrected", 16'(exp_r.data_corrected), 16'(act_r.data_corrected));
    check_field("syndrome_high", 16'(exp_r.syndrome_high), 16'(act_r.syndrome_high));
    check_field("syndrome_low", 16'(exp_r.syndrome_low), 16'(act_r.syndrome_low));
    check_field("parity_odd_high", 16'(exp_r.parity_odd_high), 16'(act_r.parity_odd_high));
    check_field("parity_odd_low", 16'(exp_r.parity_odd_low), 16'(act_r.parity_odd_low));
    check_field("status_high", 16'(exp_r.status_high), 16'(act_r.status_high));
    check_field("status_low", 16'(exp_r.status_low), 16'(act_r.status_low));
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Request driver: when the slot is free (nothing held, or the held request
  // was just taken) load the next pending request, or idle at random.
  // A stalled request is held unchanged.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(predict_codec(in_req_i));
        expected_modes.push_back(in_req_i.mode);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_valid_i <= 1'b1;
          in_req_i   <= pending_requests.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: each taken result is matched against the oldest
  // expectation; the stall is redrawn every cycle.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    hsc_pkg::out_req_t exp_r;
    logic              exp_mode;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result arrived with no request outstanding: %0h", out_req_o);
          fail_count++;
        end else begin
          exp_r    = expected_results.pop_front();
          exp_mode = expected_modes.pop_front();
          check_result(exp_r, out_req_o);
          if (exp_mode == hsc_pkg::ModeEncode) begin
            encode_seen++;
          end else begin
            decode_seen++;
            blocks_clean   += (exp_r.status_high == hsc_pkg::StNone) +
                              (exp_r.status_low == hsc_pkg::StNone);
            blocks_fixed   += (exp_r.status_high == hsc_pkg::StSingle) +
                              (exp_r.status_low == hsc_pkg::StSingle);
            blocks_flagged += (exp_r.status_high == hsc_pkg::StDouble) +
                              (exp_r.status_low == hsc_pkg::StDouble);
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any handshake on either side resets the quiet counter.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("timeout: no handshake for %0d cycles", quiet_cycles);
        $display("tb_hamming_secded_byte_pair_codec_unit NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Hold off new requests until every owed result has come back.
  task automatic wait_for_drain();
    while (pending_requests.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus sequence. Queue updates happen on the falling edge so the driver
  // never races the fill.
  // ---------------------------------------------------------------------------

  initial begin
    logic [15:0] good_word;
    int          pass_idx, k;

    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: sender lightly idle, receiver heavily stalled.
    sender_idle_pct    = 19;
    receiver_stall_pct = 72;

    // encodes at the data extremes; code_word_in is junk and must be ignored
    pending_requests.push_back(make_request(hsc_pkg::ModeEncode, 8'h00, 16'hffff));
    pending_requests.push_back(make_request(hsc_pkg::ModeEncode, 8'hff, 16'h0000));
    pending_requests.push_back(make_request(hsc_pkg::ModeEncode, 8'ha5, 16'h5a5a));
    pending_requests.push_back(make_request(hsc_pkg::ModeEncode, 8'h5a, 16'ha5a5));
    pending_requests.push_back(make_request(hsc_pkg::ModeEncode, 8'h3c, 16'h1234));
    // clean decodes, with junk in data_byte
    pending_requests.push_back(make_request(hsc_pkg::ModeDecode, 8'hff, 16'h0000));
    pending_requests.push_back(make_request(hsc_pkg::ModeDecode, 8'h00,
                               {encode_nibble(4'hf), encode_nibble(4'hf)}));
    // single flip at every bit position of both blocks, parity bit included
    good_word = {encode_nibble(4'ha), encode_nibble(4'h5)};
    for (k = 0; k < 8; k++) begin
      pending_requests.push_back(make_request(hsc_pkg::ModeDecode, 8'h00,
                                 good_word ^ (16'h0100 << k) ^ (16'h0080 >> k)));
    end
    // double flips: data pair in the high block, check and parity in the low
    pending_requests.push_back(make_request(hsc_pkg::ModeDecode, 8'h00, good_word ^ 16'h6000));
    pending_requests.push_back(make_request(hsc_pkg::ModeDecode, 8'h00, good_word ^ 16'h0081));
    // double in one block, single in the other
    pending_requests.push_back(make_request(hsc_pkg::ModeDecode, 8'h00, good_word ^ 16'h0904));
    // raw words of all ones and alternating bits
    pending_requests.push_back(make_request(hsc_pkg::ModeDecode, 8'h55, 16'hffff));
    pending_requests.push_back(make_request(hsc_pkg::ModeDecode, 8'haa, 16'haaaa));
    pending_requests.push_back(make_request(hsc_pkg::ModeDecode, 8'h00, 16'h5555));
    wait_for_drain();

    // Random part in three idling patterns; each drains fully before the next.
    for (pass_idx = 0; pass_idx < 3; pass_idx++) begin
      case (pass_idx)
        0: begin
          sender_idle_pct    = 19;
          receiver_stall_pct = 72;
        end
        1: begin
          sender_idle_pct    = 72;
          receiver_stall_pct = 19;
        end
        default: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
      endcase
      for (k = 0; k < ItemsPerPass; k++) begin
        pending_requests.push_back(random_request());
      end
      wait_for_drain();
    end

    repeat (SettleCycles) @(negedge clk_i);

    $display("covered %0d encode and %0d decode requests under three idling patterns",
             encode_seen, decode_seen);
    $display("decoded blocks: %0d clean, %0d single corrected, %0d double detected",
             blocks_clean, blocks_fixed, blocks_flagged);
    if (fail_count == 0) begin
      $display("tb_hamming_secded_byte_pair_codec_unit OK");
    end else begin
      $display("tb_hamming_secded_byte_pair_codec_unit NOT OK");
    end
    $finish;
  end

endmodule

FILE: hamming_secded_byte_pair_codec_unit.f
rtl/core/hsc_pkg.sv
rtl/core/hsc_enc_block.sv
rtl/core/hsc_dec_block.sv
rtl/core/hamming_secded_byte_pair_codec_unit.sv
sim/tb_hamming_secded_byte_pair_codec_unit.sv
